>>> rtl/core/wiep_pkg.sv
// Package with the shared types, codes and rate table of the information element parser.
package wiep_pkg;

   // Parse phase of the element walk.
   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } parse_phase_type;

   // Element type codes.
   localparam logic [7:0] IE_TYPE_SSID  = 8'd0;
   localparam logic [7:0] IE_TYPE_RATES = 8'd1;

   // Result kind codes.
   localparam logic [1:0] KIND_SSID_HDR  = 2'd0;
   localparam logic [1:0] KIND_SSID_BYTE = 2'd1;
   localparam logic [1:0] KIND_RATES_HDR = 2'd2;
   localparam logic [1:0] KIND_RATE      = 2'd3;

   // One input item.
   typedef struct packed {
      logic [7:0]  ie_byte;
      logic        first_byte;
      logic [15:0] buffer_len;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] count_or_index;
      logic [7:0] data_byte;
      logic [5:0] rate_whole;
      logic [3:0] rate_tenths;
      logic       basic_rate;
   } rsp_item_type;

   // Decoded rate in whole and tenth Mbps.
   typedef struct packed {
      logic [5:0] whole;
      logic [3:0] tenths;
   } rate_type;

   // Rate table lookup on the low seven bits of a rate code; unknown codes give zero.
   function automatic rate_type decode_rate(input logic [6:0] code);
      rate_type r;
      r = '0;
      case (code)
         7'd2:    r.whole = 6'd1;
         7'd4:    r.whole = 6'd2;
         7'd11: begin
            r.whole  = 6'd5;
            r.tenths = 4'd5;
         end
         7'd12:   r.whole = 6'd6;
         7'd18:   r.whole = 6'd9;
         7'd22:   r.whole = 6'd11;
         7'd24:   r.whole = 6'd12;
         7'd36:   r.whole = 6'd18;
         7'd44:   r.whole = 6'd22;
         7'd48:   r.whole = 6'd24;
         7'd66:   r.whole = 6'd33;
         7'd72:   r.whole = 6'd36;
         7'd96:   r.whole = 6'd48;
         7'd108:  r.whole = 6'd54;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/wiep_ifs.sv
// Valid/ready channel interfaces for the parser's input and result items.
interface wiep_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  ie_byte;
   logic        first_byte;
   logic [15:0] buffer_len;

   modport source (output valid, output ie_byte, output first_byte, output buffer_len,
                   input ready);
   modport sink   (input valid, input ie_byte, input first_byte, input buffer_len,
                   output ready);
endinterface

interface wiep_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] count_or_index;
   logic [7:0] data_byte;
   logic [5:0] rate_whole;
   logic [3:0] rate_tenths;
   logic       basic_rate;

   modport source (output valid, output kind, output count_or_index, output data_byte,
                   output rate_whole, output rate_tenths, output basic_rate,
                   input ready);
   modport sink   (input valid, input kind, input count_or_index, input data_byte,
                   input rate_whole, input rate_tenths, input basic_rate,
                   output ready);
endinterface

>>> rtl/core/wiep_parse_core.sv
// Parse state registers and the single-pass logic that handles one buffer byte.
module wiep_parse_core #(
   parameter int SSID_MAX = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  wiep_pkg::req_item_type item,
   output logic                  emit,
   output wiep_pkg::rsp_item_type result
);
   import wiep_pkg::*;

   localparam logic [7:0] SSID_MAX_B = 8'(SSID_MAX);

   parse_phase_type phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  index_ff, index_in;
   logic        stopped_ff, stopped_in;

   // Current view of the state: a first byte restarts the parse before the byte is used.
   parse_phase_type cur_phase;
   logic [15:0] cur_pos, cur_total, remain, after_len;
   logic [7:0]  cur_kind, cur_left, cur_index, left_dec;
   logic        cur_stopped;
   rate_type    rate;

   always_comb begin
      cur_phase   = item.first_byte ? PH_TYPE : phase_ff;
      cur_pos     = item.first_byte ? 16'd0 : pos_ff;
      cur_total   = item.first_byte ? item.buffer_len : total_ff;
      cur_kind    = item.first_byte ? 8'd0 : kind_ff;
      cur_left    = item.first_byte ? 8'd0 : left_ff;
      cur_index   = item.first_byte ? 8'd0 : index_ff;
      cur_stopped = item.first_byte ? 1'b0 : stopped_ff;
      remain      = cur_total - cur_pos;
      after_len   = remain - 16'd1;
      left_dec    = cur_left - 8'd1;
      rate        = decode_rate(item.ie_byte[6:0]);
   end

   // Next state and the result for the byte.
   always_comb begin
      phase_in   = cur_phase;
      pos_in     = cur_pos;
      total_in   = cur_total;
      kind_in    = cur_kind;
      left_in    = cur_left;
      index_in   = cur_index;
      stopped_in = cur_stopped;
      emit       = 1'b0;
      result     = '0;

      if (!cur_stopped && cur_pos < cur_total) begin
         case (cur_phase)
            PH_LEN: begin
               if ({8'd0, item.ie_byte} > after_len) begin
                  stopped_in = 1'b1;
               end else begin
                  left_in  = item.ie_byte;
                  index_in = 8'd0;
                  pos_in   = cur_pos + 16'd1;
                  phase_in = (item.ie_byte != 8'd0) ? PH_DATA : PH_TYPE;
                  if (cur_kind == IE_TYPE_SSID) begin
                     emit                  = 1'b1;
                     result.kind           = KIND_SSID_HDR;
                     result.count_or_index = (item.ie_byte > SSID_MAX_B) ? SSID_MAX_B
                                                                        : item.ie_byte;
                  end else if (cur_kind == IE_TYPE_RATES) begin
                     emit                  = 1'b1;
                     result.kind           = KIND_RATES_HDR;
                     result.count_or_index = item.ie_byte;
                  end
               end
            end
            PH_DATA: begin
               if (cur_kind == IE_TYPE_SSID) begin
                  if (cur_index < SSID_MAX_B) begin
                     emit                  = 1'b1;
                     result.kind           = KIND_SSID_BYTE;
                     result.count_or_index = cur_index;
                     result.data_byte      = item.ie_byte;
                  end
               end else if (cur_kind == IE_TYPE_RATES) begin
                  emit                  = 1'b1;
                  result.kind           = KIND_RATE;
                  result.count_or_index = cur_index;
                  result.data_byte      = item.ie_byte;
                  result.rate_whole     = rate.whole;
                  result.rate_tenths    = rate.tenths;
                  result.basic_rate     = item.ie_byte[7];
               end
               index_in = cur_index + 8'd1;
               left_in  = left_dec;
               pos_in   = cur_pos + 16'd1;
               if (left_dec == 8'd0) begin
                  phase_in = PH_TYPE;
               end
            end
            default: begin
               // Type byte; an unused phase code behaves the same way.
               if (remain < 16'd2) begin
                  stopped_in = 1'b1;
               end else begin
                  kind_in  = item.ie_byte;
                  phase_in = PH_LEN;
                  pos_in   = cur_pos + 16'd1;
               end
            end
         endcase
      end
   end

   // State registers advance only when the byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         pos_ff     <= 16'd0;
         total_ff   <= 16'd0;
         kind_ff    <= 8'd0;
         left_ff    <= 8'd0;
         index_ff   <= 8'd0;
         stopped_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         total_ff   <= total_in;
         kind_ff    <= kind_in;
         left_ff    <= left_in;
         index_ff   <= index_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

>>> rtl/core/wifi_info_element_parser.sv
// Top level of the information element parser: input register, parse core, result register.
//
//   Channel   Role    Handshake        Payload
//   req_ch    sink    valid / ready    ie_byte, first_byte, buffer_len
//   rsp_ch    source  valid / ready    kind, count_or_index, data_byte, rate fields
//
// Each byte is held in the input register and parsed combinationally; its result, if any, is
// registered in the result register; one byte is taken per cycle unless the result stalls.
// Reset is synchronous and returns the parse to the type phase with a zero length.
// A stalled result register holds the byte in the input register; both stages keep
// their contents, and a byte is accepted whenever the input register moves on.
module wifi_info_element_parser #(
   parameter int SSID_MAX = 32
) (
   input  logic            clock,
   input  logic            reset,
   wiep_req_if.sink        req_ch,
   wiep_rsp_if.source      rsp_ch
);
   import wiep_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   logic         out_free, step_en, emit;
   rsp_item_type result;

   // Handshake: the byte in the input register is parsed once the result register has room.
   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign step_en       = in_valid_ff && out_free;
   assign req_ch.ready  = !in_valid_ff || step_en;
   assign in_valid_in   = req_ch.ready ? req_ch.valid : in_valid_ff;
   assign out_valid_in  = out_free ? (step_en && emit) : out_valid_ff;

   wiep_parse_core #(
      .SSID_MAX (SSID_MAX)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .emit    (emit),
      .result  (result)
   );

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_item_ff.ie_byte    <= req_ch.ie_byte;
         in_item_ff.first_byte <= req_ch.first_byte;
         in_item_ff.buffer_len <= req_ch.buffer_len;
      end
      if (step_en && emit) begin
         out_item_ff <= result;
      end
   end

   // Result channel outputs.
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_item_ff.kind;
   assign rsp_ch.count_or_index = out_item_ff.count_or_index;
   assign rsp_ch.data_byte      = out_item_ff.data_byte;
   assign rsp_ch.rate_whole     = out_item_ff.rate_whole;
   assign rsp_ch.rate_tenths    = out_item_ff.rate_tenths;
   assign rsp_ch.basic_rate     = out_item_ff.basic_rate;

endmodule
